>>> sv/dcwb_pkg.sv
// shared types and constants for the dual crop coefficient water balance block
`default_nettype none
package dcwb_pkg;

    localparam int COEF_FRAC_BITS_DEF = 14;

    localparam int ACC_W = 48;
    localparam int MUL_W = 24;
    localparam int DIV_W = 28;
    localparam int CNT_W = 6;

    localparam int ET_IN_W   = 16;
    localparam int RAIN_IN_W = 21;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 48;

    localparam int CROP_ET_W = 16;
    localparam int KC_EFF_W  = 16;
    localparam int KS_OUT_W  = 15;
    localparam int ROOT_W    = 17;
    localparam int PERC_W    = 20;
    localparam int IRR_W     = 17;
    localparam int RUNOFF_W  = 20;

    localparam int DAY_W     = 11;
    localparam int DAY_MAX   = 2047;
    localparam int RUN_THRESH = 35560;
    localparam int RUN_OFFSET = 142240;

    localparam logic [16:0] TAW_RST   = 17'd10000;
    localparam logic [16:0] RAW_RST   = 17'd5000;
    localparam logic [14:0] KMAX_RST  = 15'd19661;
    localparam logic [14:0] FEW_RST   = 15'd16384;
    localparam logic [31:0] EVL_RST   = 32'd163840900;
    localparam logic [35:0] STAGE_RST = 36'd4039659550;
    localparam logic [47:0] BASAL_RST = 48'd21110945352090;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TAW, REG_RAW, REG_KMAX, REG_FEW, REG_EVL, REG_STAGE, REG_BASAL, REG_AUTO
    } t_reg;

    typedef enum logic [3:0] {
        OP_RUN_SQ, OP_RUN_DIV, OP_INFIL, OP_KCB_MUL, OP_KCB_DIV, OP_KS, OP_KR,
        OP_KE_MUL, OP_KE_WF, OP_KE_CAP, OP_KBS, OP_UPTAKE, OP_EVAP, OP_FINISH
    } t_op;

    typedef struct packed {
        logic capture;
        logic start;
        logic commit;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic need;
        logic done;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> sv/dcwb_ifs.sv
// word channels of the water balance block
`default_nettype none
interface dcwb_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [dcwb_pkg::ET_IN_W-1:0]   reference_et;
    logic signed [dcwb_pkg::RAIN_IN_W-1:0] rainfall;
    logic                                  season_start;
    modport source (output valid, reference_et, rainfall, season_start, input ready);
    modport sink (input valid, reference_et, rainfall, season_start, output ready);
endinterface

interface dcwb_out_if;
    logic                            valid;
    logic                            ready;
    logic [dcwb_pkg::CROP_ET_W-1:0]  crop_et;
    logic [dcwb_pkg::KC_EFF_W-1:0]   effective_coefficient;
    logic [dcwb_pkg::KS_OUT_W-1:0]   stress_coefficient;
    logic [dcwb_pkg::ROOT_W-1:0]     root_depletion_out;
    logic [dcwb_pkg::PERC_W-1:0]     deep_percolation;
    logic [dcwb_pkg::IRR_W-1:0]      irrigation_amount;
    logic [dcwb_pkg::RUNOFF_W-1:0]   surface_runoff;
    modport source (output valid, crop_et, effective_coefficient, stress_coefficient,
                    root_depletion_out, deep_percolation, irrigation_amount,
                    surface_runoff, input ready);
    modport sink (input valid, crop_et, effective_coefficient, stress_coefficient,
                  root_depletion_out, deep_percolation, irrigation_amount,
                  surface_runoff, output ready);
endinterface

interface dcwb_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [dcwb_pkg::CFG_IDX_W-1:0] index;
    logic [dcwb_pkg::CFG_DAT_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> sv/dual_crop_coefficient_water_balance_top.sv
// Daily dual crop coefficient soil water balance, fixed point.
// i_in takes one word per day: reference ET, rainfall (negatives read as zero)
// and a season start bit that clears both depletions and the day counter.
// o_out gives one word per day: crop ET, effective coefficient, stress
// coefficient, end-of-day root depletion, percolation, irrigation and runoff.
// i_cfg writes the eight setup registers by index and is always ready; the
// user must write it only while no day is in flight, which is not enforced.
// A day is worked through by a step sequencer over one shared bit-serial
// unit that runs the multiply and divide steps; a step without arithmetic,
// or one whose condition does not hold, commits without the unit, so a dry
// day in the initial stage with no stress is shorter than a day with all
// steps active.
// One day is in flight at a time; i_in is ready whenever the sequencer is idle.
// The result sits in an output register, so the next day is taken while it
// waits; if the receiver still stalls when the next day is done, the sequencer
// holds that day until the register frees.
// Reset (synchronous, active low) loads the register defaults and clears the
// depletions and day counter; no clearing pass follows.
`default_nettype none
module dual_crop_coefficient_water_balance_top #(
    parameter int COEF_FRAC_BITS = dcwb_pkg::COEF_FRAC_BITS_DEF
) (
    input wire logic   i_clk,
    input wire logic   i_rst_n,
    dcwb_in_if.sink    i_in,
    dcwb_out_if.source o_out,
    dcwb_cfg_if.sink   i_cfg
);
    dcwb_pkg::t_cmd cmd;
    dcwb_pkg::t_sts sts;

    assign i_cfg.ready = 1'b1;

    dcwb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    dcwb_datapath #(
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_datapath (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cmd                   (cmd),
        .o_sts                   (sts),
        .i_reference_et          (i_in.reference_et),
        .i_rainfall              (i_in.rainfall),
        .i_season_start          (i_in.season_start),
        .i_cfg_we                (i_cfg.valid),
        .i_cfg_index             (i_cfg.index),
        .i_cfg_data              (i_cfg.data),
        .o_out_valid             (o_out.valid),
        .i_out_ready             (o_out.ready),
        .o_crop_et               (o_out.crop_et),
        .o_effective_coefficient (o_out.effective_coefficient),
        .o_stress_coefficient    (o_out.stress_coefficient),
        .o_root_depletion_out    (o_out.root_depletion_out),
        .o_deep_percolation      (o_out.deep_percolation),
        .o_irrigation_amount     (o_out.irrigation_amount),
        .o_surface_runoff        (o_out.surface_runoff)
    );
endmodule
`default_nettype wire

>>> sv/dcwb_arith.sv
// shared shift-add multiplier and restoring divider, one bit per cycle
`default_nettype none
module dcwb_arith (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start_mul,
    input  wire logic                       i_start_div,
    input  wire logic [dcwb_pkg::ACC_W-1:0] i_a,
    input  wire logic [dcwb_pkg::MUL_W-1:0] i_b,
    input  wire logic [dcwb_pkg::DIV_W-1:0] i_divisor,
    output logic      [dcwb_pkg::ACC_W-1:0] o_result,
    output logic                            o_done
);
    localparam int AW = dcwb_pkg::ACC_W;
    localparam int BW = dcwb_pkg::MUL_W;
    localparam int DW = dcwb_pkg::DIV_W;
    localparam int CW = dcwb_pkg::CNT_W;

    logic          r_busy;
    logic          r_done;
    logic          r_div;
    logic [CW-1:0] r_cnt;
    logic [AW-1:0] r_x;
    logic [BW-1:0] r_y;
    logic [AW-1:0] r_acc;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvs;

    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          rem_ge;

    always_comb begin
        rem_sh  = {r_rem, r_acc[AW-1]};
        rem_ge  = rem_sh >= {1'b0, r_dvs};
        rem_sub = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start_mul || i_start_div) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start_mul) begin
            r_div <= 1'b0;
            r_cnt <= CW'(BW);
            r_x   <= i_a;
            r_y   <= i_b;
            r_acc <= '0;
        end else if (i_start_div) begin
            r_div <= 1'b1;
            r_cnt <= CW'(AW);
            r_acc <= i_a;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_div) begin
                r_rem <= rem_ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
                r_acc <= {r_acc[AW-2:0], rem_ge};
            end else begin
                if (r_y[0]) begin
                    r_acc <= r_acc + r_x;
                end
                r_x <= r_x << 1;
                r_y <= r_y >> 1;
            end
        end
    end

    assign o_result = r_acc;
    assign o_done   = r_done;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start_mul || i_start_div) |-> !r_busy) else $error("start while busy");
endmodule
`default_nettype wire

>>> sv/dcwb_ctrl.sv
// step sequencer for one day of the water balance
`default_nettype none
module dcwb_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_ready,
    output dcwb_pkg::t_cmd      o_cmd,
    input  wire dcwb_pkg::t_sts i_sts
);
    typedef enum logic [1:0] {ST_IDLE, ST_STEP, ST_WAIT} t_state;

    t_state        r_state;
    dcwb_pkg::t_op r_op;

    function automatic dcwb_pkg::t_op f_next(input dcwb_pkg::t_op op);
        dcwb_pkg::t_op nxt;
        case (op)
            dcwb_pkg::OP_RUN_SQ:  nxt = dcwb_pkg::OP_RUN_DIV;
            dcwb_pkg::OP_RUN_DIV: nxt = dcwb_pkg::OP_INFIL;
            dcwb_pkg::OP_INFIL:   nxt = dcwb_pkg::OP_KCB_MUL;
            dcwb_pkg::OP_KCB_MUL: nxt = dcwb_pkg::OP_KCB_DIV;
            dcwb_pkg::OP_KCB_DIV: nxt = dcwb_pkg::OP_KS;
            dcwb_pkg::OP_KS:      nxt = dcwb_pkg::OP_KR;
            dcwb_pkg::OP_KR:      nxt = dcwb_pkg::OP_KE_MUL;
            dcwb_pkg::OP_KE_MUL:  nxt = dcwb_pkg::OP_KE_WF;
            dcwb_pkg::OP_KE_WF:   nxt = dcwb_pkg::OP_KE_CAP;
            dcwb_pkg::OP_KE_CAP:  nxt = dcwb_pkg::OP_KBS;
            dcwb_pkg::OP_KBS:     nxt = dcwb_pkg::OP_UPTAKE;
            dcwb_pkg::OP_UPTAKE:  nxt = dcwb_pkg::OP_EVAP;
            dcwb_pkg::OP_EVAP:    nxt = dcwb_pkg::OP_FINISH;
            default:              nxt = dcwb_pkg::OP_FINISH;
        endcase
        return nxt;
    endfunction

    always_comb begin
        o_in_ready    = r_state == ST_IDLE;
        o_cmd.capture = o_in_ready && i_in_valid;
        o_cmd.start   = 1'b0;
        o_cmd.commit  = 1'b0;
        o_cmd.op      = r_op;
        case (r_state)
            ST_STEP: begin
                if (r_op == dcwb_pkg::OP_FINISH) begin
                    o_cmd.commit = i_sts.out_free;
                end else if (i_sts.need) begin
                    o_cmd.start = 1'b1;
                end else begin
                    o_cmd.commit = 1'b1;
                end
            end
            ST_WAIT: o_cmd.commit = i_sts.done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= dcwb_pkg::OP_RUN_SQ;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_STEP;
                        r_op    <= dcwb_pkg::OP_RUN_SQ;
                    end
                end
                ST_STEP: begin
                    if (r_op == dcwb_pkg::OP_FINISH) begin
                        if (i_sts.out_free) begin
                            r_state <= ST_IDLE;
                        end
                    end else if (i_sts.need) begin
                        r_state <= ST_WAIT;
                    end else begin
                        r_op <= f_next(r_op);
                    end
                end
                ST_WAIT: begin
                    if (i_sts.done) begin
                        r_state <= ST_STEP;
                        r_op    <= f_next(r_op);
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_wait_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WAIT |-> (r_op != dcwb_pkg::OP_INFIL && r_op != dcwb_pkg::OP_FINISH))
        else $error("waiting on a step without arithmetic");
endmodule
`default_nettype wire

>>> sv/dcwb_datapath.sv
// water balance registers, step operands and result register
`default_nettype none
module dcwb_datapath #(
    parameter int COEF_FRAC_BITS = dcwb_pkg::COEF_FRAC_BITS_DEF
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire dcwb_pkg::t_cmd                        i_cmd,
    output dcwb_pkg::t_sts                             o_sts,
    input  wire logic signed [dcwb_pkg::ET_IN_W-1:0]   i_reference_et,
    input  wire logic signed [dcwb_pkg::RAIN_IN_W-1:0] i_rainfall,
    input  wire logic                                  i_season_start,
    input  wire logic                                  i_cfg_we,
    input  wire logic [dcwb_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [dcwb_pkg::CFG_DAT_W-1:0]        i_cfg_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_ready,
    output logic [dcwb_pkg::CROP_ET_W-1:0]             o_crop_et,
    output logic [dcwb_pkg::KC_EFF_W-1:0]              o_effective_coefficient,
    output logic [dcwb_pkg::KS_OUT_W-1:0]              o_stress_coefficient,
    output logic [dcwb_pkg::ROOT_W-1:0]                o_root_depletion_out,
    output logic [dcwb_pkg::PERC_W-1:0]                o_deep_percolation,
    output logic [dcwb_pkg::IRR_W-1:0]                 o_irrigation_amount,
    output logic [dcwb_pkg::RUNOFF_W-1:0]              o_surface_runoff
);
    localparam int F    = COEF_FRAC_BITS;
    localparam int K_W  = F + 1;
    localparam int UP_W = 31 - F;
    localparam int EV_W = 30 - F;
    localparam int DR_W = (UP_W > 17 ? UP_W : 17) + 1;
    localparam int AW   = dcwb_pkg::ACC_W;
    localparam int BW   = dcwb_pkg::MUL_W;
    localparam int DW   = dcwb_pkg::DIV_W;
    localparam int DYW  = dcwb_pkg::DAY_W;
    localparam logic [K_W-1:0] ONE = K_W'(1) << F;

    // configuration
    logic [16:0] r_taw, r_raw;
    logic [14:0] r_kmax, r_few;
    logic [31:0] r_evl;
    logic [35:0] r_stage;
    logic [47:0] r_basal;
    logic        r_auto;

    // day state
    logic [16:0]    r_root;
    logic [15:0]    r_surf;
    logic [DYW-1:0] r_day;

    // working values
    logic [14:0]     r_et0;
    logic [19:0]     r_rain;
    logic [19:0]     r_runoff;
    logic [19:0]     r_surplus;
    logic [AW-1:0]   r_tmp;
    logic [15:0]     r_kcb;
    logic [K_W-1:0]  r_ks, r_kr;
    logic [14:0]     r_ke;
    logic [15:0]     r_kbs;
    logic [UP_W-1:0] r_up;
    logic [EV_W-1:0] r_ev;

    logic r_out_valid;
    logic [dcwb_pkg::CROP_ET_W-1:0] r_o_et;
    logic [dcwb_pkg::KC_EFF_W-1:0]  r_o_kc;
    logic [dcwb_pkg::KS_OUT_W-1:0]  r_o_ks;
    logic [dcwb_pkg::ROOT_W-1:0]    r_o_root;
    logic [dcwb_pkg::PERC_W-1:0]    r_o_perc;
    logic [dcwb_pkg::IRR_W-1:0]     r_o_irr;
    logic [dcwb_pkg::RUNOFF_W-1:0]  r_o_run;

    logic [AW-1:0] res;
    logic          unit_done;
    logic [AW-1:0] op_a;
    logic [BW-1:0] op_b;
    logic [DW-1:0] op_d;
    logic          op_div;

    logic [15:0] rew, tew;
    logic [23:0] r13, run_a, run_s;
    logic [27:0] run_den;
    logic        need_run;
    logic [19:0] runoff_n, infil, excess, surplus_n;
    logic [15:0] fill;
    logic [16:0] recharge;

    logic [8:0]     li, ld, lm, ll, len;
    logic [DYW-1:0] t_ini, t_dev, t_mid, t_late, t_base, num;
    logic [15:0]    kini, kmid, kend, k_lo, k_hi, k_mag, kcb_flat, kcb_interp;
    logic           in_ini, in_dev, in_mid, in_late, interp, k_neg;

    logic           dr_gt, taw_nz, need_ks, de_gt, need_kr, need_ke;
    logic [K_W-1:0] ks_flat, kr_flat;
    logic [15:0]    cap;
    logic [AW-1:0]  wf_lim;

    logic [23:0]     etc_sum, dp_sum, de2;
    logic [16:0]     kce;
    logic [DR_W-1:0] dr2;
    logic            over, irr_on;
    logic [16:0]     dr3, dr4, irr;
    logic [15:0]     de3;

    dcwb_arith u_arith (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start_mul (i_cmd.start && !op_div),
        .i_start_div (i_cmd.start && op_div),
        .i_a         (op_a),
        .i_b         (op_b),
        .i_divisor   (op_d),
        .o_result    (res),
        .o_done      (unit_done)
    );

    always_comb begin
        rew = r_evl[15:0];
        tew = r_evl[31:16];

        // runoff, cn 65
        r13      = ({4'b0, r_rain} << 3) + ({4'b0, r_rain} << 2) + {4'b0, r_rain};
        need_run = r13 > 24'(dcwb_pkg::RUN_THRESH);
        run_a    = r13 - 24'(dcwb_pkg::RUN_THRESH);
        run_s    = r13 + 24'(dcwb_pkg::RUN_OFFSET);
        run_den  = ({4'b0, run_s} << 3) + ({4'b0, run_s} << 2) + {4'b0, run_s};
        runoff_n = (res > AW'(r_rain)) ? r_rain : res[19:0];

        // infiltration
        infil     = r_rain - r_runoff;
        fill      = (infil > {4'b0, r_surf}) ? r_surf : infil[15:0];
        excess    = infil - {4'b0, fill};
        recharge  = (excess > {3'b0, r_root}) ? r_root : excess[16:0];
        surplus_n = excess - {3'b0, recharge};

        // basal coefficient by stage
        li      = r_stage[8:0];
        ld      = r_stage[17:9];
        lm      = r_stage[26:18];
        ll      = r_stage[35:27];
        kini    = r_basal[15:0];
        kmid    = r_basal[31:16];
        kend    = r_basal[47:32];
        t_ini   = DYW'(li);
        t_dev   = t_ini + DYW'(ld);
        t_mid   = t_dev + DYW'(lm);
        t_late  = t_mid + DYW'(ll);
        in_ini  = r_day <= t_ini;
        in_dev  = r_day < t_dev;
        in_mid  = r_day < t_mid;
        in_late = r_day < t_late;
        interp  = !in_ini && (in_dev || (!in_mid && in_late));
        k_lo    = in_dev ? kini : kmid;
        k_hi    = in_dev ? kmid : kend;
        t_base  = in_dev ? t_ini : t_mid;
        len     = in_dev ? ld : ll;
        num     = r_day - t_base;
        k_neg   = k_hi < k_lo;
        k_mag   = k_neg ? k_lo - k_hi : k_hi - k_lo;
        kcb_flat   = in_ini ? kini : (in_mid ? kmid : kend);
        kcb_interp = k_neg ? k_lo - res[15:0] : k_lo + res[15:0];

        // stress and evaporation reduction
        dr_gt   = r_root > r_raw;
        taw_nz  = r_taw != '0;
        need_ks = dr_gt && taw_nz && (r_root < r_taw);
        ks_flat = (dr_gt && taw_nz) ? '0 : ONE;
        de_gt   = r_surf > rew;
        need_kr = de_gt && (r_surf < tew);
        kr_flat = de_gt ? '0 : ONE;
        need_ke = {1'b0, r_kmax} > r_kcb;
        cap     = (tew > r_surf) ? tew - r_surf : '0;
        wf_lim  = res >> F;

        // end of day
        etc_sum = 24'(r_up) + 24'(r_ev);
        kce     = 17'(r_kbs) + 17'(r_ke);
        dr2     = DR_W'(r_root) + DR_W'(r_up);
        over    = dr2 > DR_W'(r_taw);
        dr3     = over ? r_taw : dr2[16:0];
        dp_sum  = 24'(r_surplus) + (over ? 24'(dr2 - DR_W'(r_taw)) : 24'd0);
        irr_on  = r_auto && (dr3 > r_raw);
        irr     = irr_on ? dr3 : '0;
        dr4     = irr_on ? '0 : dr3;
        de2     = 24'(r_surf) + 24'(r_ev);
        de3     = (de2 > 24'(tew)) ? tew : de2[15:0];
    end

    always_comb begin
        op_a   = '0;
        op_b   = '0;
        op_d   = '0;
        op_div = 1'b0;
        o_sts.need = 1'b0;
        case (i_cmd.op)
            dcwb_pkg::OP_RUN_SQ: begin
                op_a = AW'(run_a);
                op_b = run_a;
                o_sts.need = need_run;
            end
            dcwb_pkg::OP_RUN_DIV: begin
                op_a   = r_tmp;
                op_d   = run_den;
                op_div = 1'b1;
                o_sts.need = need_run;
            end
            dcwb_pkg::OP_KCB_MUL: begin
                op_a = AW'(k_mag);
                op_b = BW'(num);
                o_sts.need = interp;
            end
            dcwb_pkg::OP_KCB_DIV: begin
                op_a   = r_tmp;
                op_d   = DW'(len);
                op_div = 1'b1;
                o_sts.need = interp;
            end
            dcwb_pkg::OP_KS: begin
                op_a   = AW'(r_taw - r_root) << F;
                op_d   = DW'(r_taw - r_raw);
                op_div = 1'b1;
                o_sts.need = need_ks;
            end
            dcwb_pkg::OP_KR: begin
                op_a   = AW'(tew - r_surf) << F;
                op_d   = DW'(tew - rew);
                op_div = 1'b1;
                o_sts.need = need_kr;
            end
            dcwb_pkg::OP_KE_MUL: begin
                op_a = AW'({1'b0, r_kmax} - r_kcb);
                op_b = BW'(r_kr);
                o_sts.need = need_ke;
            end
            dcwb_pkg::OP_KE_WF: begin
                op_a = AW'(r_few);
                op_b = BW'(r_kmax);
                o_sts.need = 1'b1;
            end
            dcwb_pkg::OP_KE_CAP: begin
                op_a   = AW'(cap) << F;
                op_d   = DW'(r_et0);
                op_div = 1'b1;
                o_sts.need = r_et0 != '0;
            end
            dcwb_pkg::OP_KBS: begin
                op_a = AW'(r_kcb);
                op_b = BW'(r_ks);
                o_sts.need = 1'b1;
            end
            dcwb_pkg::OP_UPTAKE: begin
                op_a = AW'(r_kbs);
                op_b = BW'(r_et0);
                o_sts.need = 1'b1;
            end
            dcwb_pkg::OP_EVAP: begin
                op_a = AW'(r_ke);
                op_b = BW'(r_et0);
                o_sts.need = 1'b1;
            end
            default: ;
        endcase
        o_sts.done     = unit_done;
        o_sts.out_free = !r_out_valid || i_out_ready;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_taw       <= dcwb_pkg::TAW_RST;
            r_raw       <= dcwb_pkg::RAW_RST;
            r_kmax      <= dcwb_pkg::KMAX_RST;
            r_few       <= dcwb_pkg::FEW_RST;
            r_evl       <= dcwb_pkg::EVL_RST;
            r_stage     <= dcwb_pkg::STAGE_RST;
            r_basal     <= dcwb_pkg::BASAL_RST;
            r_auto      <= 1'b0;
            r_root      <= '0;
            r_surf      <= '0;
            r_day       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (dcwb_pkg::t_reg'(i_cfg_index))
                    dcwb_pkg::REG_TAW:   r_taw   <= i_cfg_data[16:0];
                    dcwb_pkg::REG_RAW:   r_raw   <= i_cfg_data[16:0];
                    dcwb_pkg::REG_KMAX:  r_kmax  <= i_cfg_data[14:0];
                    dcwb_pkg::REG_FEW:   r_few   <= i_cfg_data[14:0];
                    dcwb_pkg::REG_EVL:   r_evl   <= i_cfg_data[31:0];
                    dcwb_pkg::REG_STAGE: r_stage <= i_cfg_data[35:0];
                    dcwb_pkg::REG_BASAL: r_basal <= i_cfg_data[47:0];
                    dcwb_pkg::REG_AUTO:  r_auto  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.capture && i_season_start) begin
                r_root <= '0;
                r_surf <= '0;
                r_day  <= '0;
            end
            if (i_cmd.commit && i_cmd.op == dcwb_pkg::OP_INFIL) begin
                r_surf <= r_surf - fill;
                r_root <= r_root - recharge;
            end
            if (i_cmd.commit && i_cmd.op == dcwb_pkg::OP_FINISH) begin
                r_root      <= dr4;
                r_surf      <= de3;
                r_out_valid <= 1'b1;
                if (r_day != DYW'(dcwb_pkg::DAY_MAX)) begin
                    r_day <= r_day + DYW'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_et0  <= i_reference_et[15] ? '0 : i_reference_et[14:0];
            r_rain <= i_rainfall[20] ? '0 : i_rainfall[19:0];
        end
        if (i_cmd.commit) begin
            case (i_cmd.op)
                dcwb_pkg::OP_RUN_SQ:  r_tmp <= res;
                dcwb_pkg::OP_RUN_DIV: r_runoff <= o_sts.need ? runoff_n : '0;
                dcwb_pkg::OP_INFIL:   r_surplus <= surplus_n;
                dcwb_pkg::OP_KCB_MUL: r_tmp <= res;
                dcwb_pkg::OP_KCB_DIV: r_kcb <= o_sts.need ? kcb_interp : kcb_flat;
                dcwb_pkg::OP_KS:      r_ks <= o_sts.need ? res[K_W-1:0] : ks_flat;
                dcwb_pkg::OP_KR:      r_kr <= o_sts.need ? res[K_W-1:0] : kr_flat;
                dcwb_pkg::OP_KE_MUL:  r_ke <= o_sts.need ? res[F +: 15] : '0;
                dcwb_pkg::OP_KE_WF: begin
                    if (AW'(r_ke) > wf_lim) begin
                        r_ke <= wf_lim[14:0];
                    end
                end
                dcwb_pkg::OP_KE_CAP: begin
                    if (!o_sts.need) begin
                        r_ke <= '0;
                    end else if (AW'(r_ke) > res) begin
                        r_ke <= res[14:0];
                    end
                end
                dcwb_pkg::OP_KBS:    r_kbs <= res[F +: 16];
                dcwb_pkg::OP_UPTAKE: r_up  <= res[F +: UP_W];
                dcwb_pkg::OP_EVAP:   r_ev  <= res[F +: EV_W];
                dcwb_pkg::OP_FINISH: begin
                    r_o_et   <= (etc_sum > 24'hFFFF) ? 16'hFFFF : etc_sum[15:0];
                    r_o_kc   <= kce[16] ? 16'hFFFF : kce[15:0];
                    r_o_ks   <= dcwb_pkg::KS_OUT_W'(r_ks);
                    r_o_root <= dr4;
                    r_o_perc <= (dp_sum > 24'hFFFFF) ? 20'hFFFFF : dp_sum[19:0];
                    r_o_irr  <= irr;
                    r_o_run  <= r_runoff;
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid             = r_out_valid;
    assign o_crop_et               = r_o_et;
    assign o_effective_coefficient = r_o_kc;
    assign o_stress_coefficient    = r_o_ks;
    assign o_root_depletion_out    = r_o_root;
    assign o_deep_percolation      = r_o_perc;
    assign o_irrigation_amount     = r_o_irr;
    assign o_surface_runoff        = r_o_run;

    a_day_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && i_cmd.op == dcwb_pkg::OP_FINISH) |=> (r_root <= r_taw && r_surf <= tew))
        else $error("depletion beyond capacity at end of day");
    a_ks_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && i_cmd.op == dcwb_pkg::OP_KS) |=> r_ks <= ONE)
        else $error("stress coefficient above one");
endmodule
`default_nettype wire

>>> dv/tb_dual_crop_coefficient_water_balance_top.sv
// self-checking testbench for the dual crop coefficient water balance block
`default_nettype none
module tb_dual_crop_coefficient_water_balance_top;

    localparam int N_RANDOM = 1700;
    localparam int WATCHDOG = 20000;
    localparam logic [63:0] ONE_Q = 64'd16384;

    typedef struct packed {
        logic [15:0] crop_et;
        logic [15:0] kc_eff;
        logic [14:0] ks;
        logic [16:0] root;
        logic [19:0] perc;
        logic [16:0] irr;
        logic [19:0] runoff;
    } t_day_out;

    typedef struct {
        logic signed [15:0] et;
        logic signed [20:0] rain;
        logic               start;
        logic               typed;
        t_day_out           want;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    dcwb_in_if  in_ch();
    dcwb_out_if out_ch();
    dcwb_cfg_if cfg_ch();

    dual_crop_coefficient_water_balance_top i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch), .i_cfg(cfg_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor copy of registers and state
    logic [63:0] p_taw, p_raw, p_kmax, p_few, p_evl, p_stage, p_basal, p_auto;
    logic [63:0] p_dr, p_de;
    int unsigned p_day;

    t_day_out day_queue[$];
    t_row     rows[$];
    int       errors = 0;
    int       days_checked = 0;
    int       idle_cycles = 0;
    int       cfg_writes = 0;
    bit       quiet_rx = 1'b0;
    bit       hold_rx = 1'b0;
    bit       quiet_tx = 1'b0;
    bit       timed_out = 1'b0;

    function automatic logic [63:0] umin(logic [63:0] a, logic [63:0] b);
        return a < b ? a : b;
    endfunction

    function automatic logic [63:0] basal_coef(int unsigned day);
        longint li, ld, lm, ll, k0, k1, k2, d;
        li = 64'(p_stage[8:0]); ld = 64'(p_stage[17:9]);
        lm = 64'(p_stage[26:18]); ll = 64'(p_stage[35:27]);
        k0 = 64'(p_basal[15:0]); k1 = 64'(p_basal[31:16]); k2 = 64'(p_basal[47:32]);
        d = longint'(day);
        if (d <= li) return k0;
        if (d < li + ld) return k0 + ((k1 - k0) * (d - li)) / ld;
        if (d < li + ld + lm) return k1;
        if (d < li + ld + lm + ll) return k1 + ((k2 - k1) * (d - li - ld - lm)) / ll;
        return k2;
    endfunction

    function automatic void apply_reg(dcwb_pkg::t_reg idx, logic [47:0] v);
        case (idx)
            dcwb_pkg::REG_TAW:   p_taw = 64'(v[16:0]);
            dcwb_pkg::REG_RAW:   p_raw = 64'(v[16:0]);
            dcwb_pkg::REG_KMAX:  p_kmax = 64'(v[14:0]);
            dcwb_pkg::REG_FEW:   p_few = 64'(v[14:0]);
            dcwb_pkg::REG_EVL:   p_evl = 64'(v[31:0]);
            dcwb_pkg::REG_STAGE: p_stage = 64'(v[35:0]);
            dcwb_pkg::REG_BASAL: p_basal = 64'(v[47:0]);
            default:             p_auto = 64'(v[0]);
        endcase
    endfunction

    function automatic t_day_out water_balance_day(logic signed [15:0] et_in,
                                                   logic signed [20:0] rain_in, logic st);
        logic [63:0] et0, rain, rew, tew, dr, de, runoff, infil, fill, excess, rech, surplus;
        logic [63:0] kcb, ks, kr, ke, cap, uptake, evap, kbs, kc, etc, dp, irr, a;
        t_day_out o;
        et0 = (et_in < 0) ? 64'd0 : 64'(et_in);
        rain = (rain_in < 0) ? 64'd0 : 64'(rain_in);
        rew = 64'(p_evl[15:0]); tew = 64'(p_evl[31:16]);
        ks = ONE_Q; kr = ONE_Q; ke = 64'd0; runoff = 64'd0; irr = 64'd0;
        if (st) begin
            p_dr = 64'd0; p_de = 64'd0; p_day = 0;
        end
        dr = p_dr; de = p_de;
        if (13 * rain > 35560) begin
            a = 13 * rain - 35560;
            runoff = umin((a * a) / (13 * (13 * rain + 142240)), rain);
        end
        infil = rain - runoff;
        fill = umin(infil, de);
        de -= fill;
        excess = infil - fill;
        rech = umin(excess, dr);
        dr -= rech;
        surplus = excess - rech;
        kcb = basal_coef(p_day);
        if (dr > p_raw && p_taw > 0)
            ks = (dr >= p_taw) ? 64'd0 : ((p_taw - dr) * ONE_Q) / (p_taw - p_raw);
        if (de > rew)
            kr = (de >= tew) ? 64'd0 : ((tew - de) * ONE_Q) / (tew - rew);
        if (p_kmax > kcb) ke = (kr * (p_kmax - kcb)) >> 14;
        ke = umin(ke, (p_few * p_kmax) >> 14);
        cap = (tew > de) ? tew - de : 64'd0;
        ke = (et0 > 0) ? umin(ke, (cap * ONE_Q) / et0) : 64'd0;
        kbs = (kcb * ks) >> 14;
        kc = kbs + ke;
        uptake = (kbs * et0) >> 14;
        evap = (ke * et0) >> 14;
        etc = uptake + evap;
        dr += uptake;
        de = umin(de + evap, tew);
        dp = surplus;
        if (dr > p_taw) begin
            dp += dr - p_taw;
            dr = p_taw;
        end
        if (p_auto[0] && dr > p_raw) begin
            irr = dr;
            dr = 64'd0;
        end
        p_dr = 64'(dr[16:0]);
        p_de = 64'(de[15:0]);
        if (p_day < 2047) p_day++;
        o.crop_et = 16'(umin(etc, 64'hFFFF));
        o.kc_eff = 16'(umin(kc, 64'hFFFF));
        o.ks = ks[14:0];
        o.root = dr[16:0];
        o.perc = 20'(umin(dp, 64'hFFFFF));
        o.irr = irr[16:0];
        o.runoff = runoff[19:0];
        return o;
    endfunction

    task automatic cfg_write(dcwb_pkg::t_reg idx, logic [47:0] v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        apply_reg(idx, v);
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (day_queue.size() != 0 && !timed_out) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic send_day(logic signed [15:0] et, logic signed [20:0] rain, logic st,
                            bit typed, t_day_out want, bit stall_ok);
        t_day_out p;
        while (stall_ok && !quiet_tx && $urandom_range(99) < 10) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.reference_et <= et;
        in_ch.rainfall <= rain;
        in_ch.season_start <= st;
        @(posedge i_clk);
        while (!in_ch.ready && !timed_out) @(posedge i_clk);
        p = water_balance_day(et, rain, st);
        if (typed && p != want) begin
            errors++;
            if (errors <= 10)
                $display("table row disagrees with predictor: row %h pred %h", want, p);
        end
        day_queue.push_back(p);
    endtask

    function automatic t_day_out typed_out(int et, int k, int ks, int rt, int irr);
        t_day_out o;
        o = '0;
        o.crop_et = 16'(et); o.kc_eff = 16'(k); o.ks = 15'(ks); o.root = 17'(rt);
        o.irr = 17'(irr);
        return o;
    endfunction

    // receiver with random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (day_queue.size() == 0) begin
                    errors++;
                    if (errors <= 10) $display("unexpected result word %h", out_ch.crop_et);
                end else begin
                    t_day_out w, g;
                    w = day_queue.pop_front();
                    g = '{out_ch.crop_et, out_ch.effective_coefficient,
                          out_ch.stress_coefficient, out_ch.root_depletion_out,
                          out_ch.deep_percolation, out_ch.irrigation_amount,
                          out_ch.surface_runoff};
                    days_checked++;
                    if (g !== w) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: exp et=%0d kc=%0d ks=%0d dr=%0d dp=%0d ir=%0d ro=%0d got et=%0d kc=%0d ks=%0d dr=%0d dp=%0d ir=%0d ro=%0d",
                                w.crop_et, w.kc_eff, w.ks, w.root, w.perc, w.irr, w.runoff,
                                g.crop_et, g.kc_eff, g.ks, g.root, g.perc, g.irr, g.runoff);
                    end
                end
            end
            out_ch.ready <= hold_rx ? 1'b0 : (quiet_rx || $urandom_range(99) >= 10);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG && !timed_out) begin
            timed_out = 1'b1;
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic logic [47:0] rand_reg(dcwb_pkg::t_reg idx);
        case (idx)
            dcwb_pkg::REG_TAW:   return 48'($urandom_range(100000));
            dcwb_pkg::REG_RAW:   return 48'($urandom_range(100000));
            dcwb_pkg::REG_KMAX:  return 48'($urandom_range(32767));
            dcwb_pkg::REG_FEW:   return 48'($urandom_range(16384));
            dcwb_pkg::REG_EVL:   return 48'({16'($urandom_range(6000)),
                                             16'($urandom_range(3000))});
            dcwb_pkg::REG_STAGE: return 48'({4'(0), 9'($urandom_range(511)),
                                             9'($urandom_range(60)), 9'($urandom_range(60)),
                                             9'($urandom_range(60))});
            dcwb_pkg::REG_BASAL: return {16'($urandom), 16'($urandom), 16'($urandom)};
            default:             return 48'($urandom_range(1));
        endcase
    endfunction

    initial begin
        t_row r;
        in_ch.valid = 1'b0; in_ch.reference_et = '0; in_ch.rainfall = '0;
        in_ch.season_start = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.index = '0; cfg_ch.data = '0;
        p_taw = 64'(dcwb_pkg::TAW_RST); p_raw = 64'(dcwb_pkg::RAW_RST);
        p_kmax = 64'(dcwb_pkg::KMAX_RST); p_few = 64'(dcwb_pkg::FEW_RST);
        p_evl = 64'(dcwb_pkg::EVL_RST); p_stage = 64'(dcwb_pkg::STAGE_RST);
        p_basal = 64'(dcwb_pkg::BASAL_RST); p_auto = 64'd0;
        p_dr = 64'd0; p_de = 64'd0; p_day = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: the one typed row reads off the defaults at a glance
        rows.push_back('{16'sd0, 21'sd0, 1'b1, 1'b1, typed_out(0, 2458, 16384, 0, 0)});
        rows.push_back('{-16'sd32768, -21'sd1048576, 1'b0, 1'b0, '0});
        rows.push_back('{16'sd32767, 21'sd0, 1'b0, 1'b0, '0});
        rows.push_back('{16'sd32767, 21'sd1048575, 1'b0, 1'b0, '0});
        rows.push_back('{16'sd500, 21'sd2735, 1'b0, 1'b0, '0});
        rows.push_back('{16'sd500, 21'sd2736, 1'b0, 1'b0, '0});
        rows.push_back('{16'sd800, 21'sd0, 1'b0, 1'b0, '0});
        rows.push_back('{16'sd800, -21'sd5, 1'b1, 1'b0, '0});
        for (int i = 0; i < 12; i++) rows.push_back('{16'sd2000, 21'sd0, 1'b0, 1'b0, '0});
        rows.push_back('{16'sd1, 21'sd1, 1'b0, 1'b0, '0});
        rows.push_back('{16'sd0, 21'sd20000, 1'b0, 1'b0, '0});
        foreach (rows[i])
            send_day(rows[i].et, rows[i].rain, rows[i].start, rows[i].typed, rows[i].want, 1);
        wait_drained();

        // extreme settings, irrigation on
        cfg_write(dcwb_pkg::REG_TAW, 48'd0);
        cfg_write(dcwb_pkg::REG_RAW, 48'd100000);
        cfg_write(dcwb_pkg::REG_KMAX, 48'd32767);
        cfg_write(dcwb_pkg::REG_FEW, 48'd0);
        cfg_write(dcwb_pkg::REG_EVL, 48'hFFFFFFFF);
        cfg_write(dcwb_pkg::REG_STAGE, 48'hF_FFFF_FFFF);
        cfg_write(dcwb_pkg::REG_BASAL, 48'hFFFF_FFFF_FFFF);
        cfg_write(dcwb_pkg::REG_AUTO, 48'd1);
        for (int i = 0; i < 5; i++)
            send_day(16'($urandom), 21'($urandom), 1'b0, 0, '0, 1);
        wait_drained();
        cfg_write(dcwb_pkg::REG_TAW, 48'd100000);
        cfg_write(dcwb_pkg::REG_RAW, 48'd0);
        cfg_write(dcwb_pkg::REG_STAGE, 48'd0);
        cfg_write(dcwb_pkg::REG_EVL, 48'd0);
        for (int i = 0; i < 5; i++)
            send_day(16'($urandom), 21'($urandom), 1'b0, 0, '0, 1);
        wait_drained();

        // random phases; phase 1 is stall free, phase 2 has the long hold-off
        for (int ph = 0; ph < 8; ph++) begin
            quiet_tx = (ph == 1); quiet_rx = (ph == 1);
            for (int k = 0; k < 8; k++)
                if ($urandom_range(1))
                    cfg_write(dcwb_pkg::t_reg'(k), rand_reg(dcwb_pkg::t_reg'(k)));
            if (ph == 2) begin
                fork
                    begin
                        hold_rx = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        hold_rx = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < N_RANDOM / 8; n++) begin
                logic signed [15:0] et;
                logic signed [20:0] rain;
                et = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(1500));
                case ($urandom_range(9))
                    0: rain = 21'($urandom);
                    1, 2: rain = 21'($urandom_range(60000));
                    default: rain = ($urandom_range(2) == 0) ? 21'($urandom_range(3000))
                                                              : 21'(0);
                endcase
                send_day(et, rain, ($urandom_range(150) == 0) || n == 0, 0, '0, 1);
            end
            wait_drained();
        end
        quiet_tx = 0; quiet_rx = 0;
        wait_drained();

        $display("covered %0d checked days with %0d register writes over directed, extreme",
                 days_checked, cfg_writes);
        $display("and random phases including a long receiver hold-off");
        if (errors == 0 && day_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> filelist.f
sv/dcwb_pkg.sv
sv/dcwb_ifs.sv
sv/dcwb_arith.sv
sv/dcwb_ctrl.sv
sv/dcwb_datapath.sv
sv/dual_crop_coefficient_water_balance_top.sv
dv/tb_dual_crop_coefficient_water_balance_top.sv
